>>> hw/rtl/ptbc_pkg.sv
package ptbc_pkg;

    localparam int MIN_LEN             = 26;
    localparam int BRACKET_POS         = 8;
    localparam int YEAR_POS            = 15;
    localparam int MONTH_POS           = 17;
    localparam int DAY_POS             = 19;
    localparam int HOUR_POS            = 21;
    localparam int MINUTE_POS          = 23;
    localparam int WEEKDAY_POS         = 25;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] CHAR_BRACKET = 8'h5D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam logic [6:0] MONTH_FIRST  = 7'd1;
    localparam logic [6:0] MONTH_LAST   = 7'd12;
    localparam logic [6:0] MONTH_FEB    = 7'd2;
    localparam logic [6:0] MONTH_MAR    = 7'd3;
    localparam logic [6:0] HOUR_MAX     = 7'd23;
    localparam logic [6:0] MINUTE_MAX   = 7'd59;
    localparam logic [3:0] WEEKDAY_MAX  = 4'd6;
    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

    typedef struct packed {
        logic       ok;
        logic [6:0] year;
        logic [6:0] month;
        logic [6:0] day;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [3:0] weekday;
    } rec_t;

    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] r;
        unique case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] r;
        unique case (m)
            4'd2:                     r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
            default:                  r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] mod7(input logic [8:0] x);
        logic [4:0] a;
        logic [3:0] b;
        a = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]);
        b = 4'(a[2:0]) + 4'(a[4:3]);
        if (b >= 4'd7)
        begin
            b = b - 4'd7;
        end
        return b[2:0];
    endfunction

    function automatic logic [6:0] acc_digit(input logic [6:0] v, input logic [3:0] dg);
        return 7'({v, 3'b000}) + 7'({v, 1'b0}) + 7'(dg);
    endfunction

endpackage

>>> hw/rtl/pager_time_broadcast_checker.sv
// Pager time broadcast checker.
// Input channel: one message character per request (char_code, last_char),
// handshake in_valid / in_stall. The character with last_char set closes the
// message. Output channel: one result per message (valid_res and the decoded
// date and time fields), handshake out_valid / out_stall.
// The front end takes one character every cycle unless stalled and gathers
// the digits; on the last character it pushes a record into a short queue
// (QUEUE_DEPTH entries). The back end checks ranges, the leap rule and the
// weekday combinationally into the output register.
// Throughput when not stalled: one character per cycle, one result per cycle.
// Result path: the record is written into the queue, then into the output
// register once it heads the queue and the output register is free.
// When the receiver stalls, the result holds; later records wait in the queue,
// and in_stall rises only when the queue is full.
// Reset clears the character position, gathered digits, queue and output
// valid; the block accepts characters from the first cycle after reset.
module pager_time_broadcast_checker
    import ptbc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       valid_res,
    output logic [6:0] year_in_century,
    output logic [3:0] month,
    output logic [4:0] day,
    output logic [4:0] hour,
    output logic [5:0] minute,
    output logic [2:0] weekday
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    rec_t push_rec;
    rec_t pop_rec;

    ptbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (push_rec)
    );

    ptbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .empty    (q_empty)
    );

    ptbc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_rec           (pop_rec),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .valid_res       (valid_res),
        .year_in_century (year_in_century),
        .month           (month),
        .day             (day),
        .hour            (hour),
        .minute          (minute),
        .weekday         (weekday)
    );

endmodule

>>> hw/rtl/ptbc_front.sv
module ptbc_front
    import ptbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  logic       q_full,
    output logic       q_push,
    output rec_t       q_rec
);

    logic [4:0] pos_reg,     pos_next;
    logic [6:0] year_reg,    year_next;
    logic [6:0] month_reg,   month_next;
    logic [6:0] day_reg,     day_next;
    logic [6:0] hour_reg,    hour_next;
    logic [6:0] minute_reg,  minute_next;
    logic [3:0] wd_reg,      wd_next;
    logic       bad_reg,     bad_next;

    logic       accept;
    logic       active;
    logic       is_digit;
    logic [3:0] dg;
    logic [7:0] dg_full;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign active   = pos_reg < 5'(MIN_LEN);
    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign dg_full  = char_code - CHAR_ZERO;
    assign dg       = dg_full[3:0];

    always_comb
    begin
        pos_next    = pos_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        wd_next     = wd_reg;
        bad_next    = bad_reg;
        if (active)
        begin
            pos_next = pos_reg + 5'd1;
            if (pos_reg == 5'(BRACKET_POS) && char_code != CHAR_BRACKET)
            begin
                bad_next = 1'b1;
            end
            if (pos_reg >= 5'(YEAR_POS))
            begin
                if (!is_digit)
                begin
                    bad_next = 1'b1;
                end
                else if (pos_reg < 5'(MONTH_POS))
                begin
                    year_next = acc_digit(year_reg, dg);
                end
                else if (pos_reg < 5'(DAY_POS))
                begin
                    month_next = acc_digit(month_reg, dg);
                end
                else if (pos_reg < 5'(HOUR_POS))
                begin
                    day_next = acc_digit(day_reg, dg);
                end
                else if (pos_reg < 5'(MINUTE_POS))
                begin
                    hour_next = acc_digit(hour_reg, dg);
                end
                else if (pos_reg < 5'(WEEKDAY_POS))
                begin
                    minute_next = acc_digit(minute_reg, dg);
                end
                else
                begin
                    wd_next = dg;
                end
            end
        end
    end

    assign q_push         = accept && last_char;
    assign q_rec.ok       = (pos_next >= 5'(MIN_LEN)) && !bad_next;
    assign q_rec.year     = year_next;
    assign q_rec.month    = month_next;
    assign q_rec.day      = day_next;
    assign q_rec.hour     = hour_next;
    assign q_rec.minute   = minute_next;
    assign q_rec.weekday  = wd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            wd_reg     <= '0;
            bad_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                pos_reg    <= '0;
                year_reg   <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                hour_reg   <= '0;
                minute_reg <= '0;
                wd_reg     <= '0;
                bad_reg    <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                wd_reg     <= wd_next;
                bad_reg    <= bad_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 5'(MIN_LEN))
        else $error("position counter past saturation");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (pos_reg == 5'd0) && !bad_reg)
        else $error("state not cleared after last character");
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("request pushed into full queue");
`endif

endmodule

>>> hw/rtl/ptbc_queue.sv
module ptbc_queue
    import ptbc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output rec_t pop_rec,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    assign full    = cnt_reg == CNT_W'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign pop_rec = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
`endif

endmodule

>>> hw/rtl/ptbc_back.sv
module ptbc_back
    import ptbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  rec_t       q_rec,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       valid_res,
    output logic [6:0] year_in_century,
    output logic [3:0] month,
    output logic [4:0] day,
    output logic [4:0] hour,
    output logic [5:0] minute,
    output logic [2:0] weekday
);

    logic       out_valid_reg;
    logic       ok_reg,   ok_next;
    logic [6:0] year_reg, year_next;
    logic [3:0] mon_reg,  mon_next;
    logic [4:0] day_reg,  day_next;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] min_reg,  min_next;
    logic [2:0] wd_reg,   wd_next;

    logic       month_ok;
    logic       day_ok;
    logic       early;
    logic [4:0] mlen;
    logic [7:0] u;
    logic [8:0] dow_sum;
    logic [2:0] dow;

    assign q_pop = !q_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        month_ok = (q_rec.month >= MONTH_FIRST) && (q_rec.month <= MONTH_LAST);
        if (q_rec.month == MONTH_FEB && q_rec.year[1:0] == 2'b00)
        begin
            mlen = FEB_LEAP_LEN;
        end
        else
        begin
            mlen = month_days(q_rec.month[3:0]);
        end
        day_ok  = (q_rec.day != 7'd0) && (q_rec.day <= 7'(mlen));
        early   = q_rec.month < MONTH_MAR;
        u       = 8'(q_rec.year) + 8'd4 - 8'(early);
        dow_sum = 9'd2 + 9'(u) + 9'(u[7:2]) + 9'(month_offset(q_rec.month[3:0]))
                  + 9'(q_rec.day);
        dow     = mod7(dow_sum);
        ok_next = q_rec.ok && month_ok && day_ok && (q_rec.hour <= HOUR_MAX)
                  && (q_rec.minute <= MINUTE_MAX) && (q_rec.weekday <= WEEKDAY_MAX)
                  && (q_rec.weekday == 4'(dow));
        year_next = ok_next ? q_rec.year            : '0;
        mon_next  = ok_next ? q_rec.month[3:0]      : '0;
        day_next  = ok_next ? q_rec.day[4:0]        : '0;
        hour_next = ok_next ? q_rec.hour[4:0]       : '0;
        min_next  = ok_next ? q_rec.minute[5:0]     : '0;
        wd_next   = ok_next ? q_rec.weekday[2:0]    : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ok_reg   <= ok_next;
            year_reg <= year_next;
            mon_reg  <= mon_next;
            day_reg  <= day_next;
            hour_reg <= hour_next;
            min_reg  <= min_next;
            wd_reg   <= wd_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign valid_res       = ok_reg;
    assign year_in_century = year_reg;
    assign month           = mon_reg;
    assign day             = day_reg;
    assign hour            = hour_reg;
    assign minute          = min_reg;
    assign weekday         = wd_reg;

`ifndef SYNTHESIS
    a_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> year_in_century == '0 && month == '0 && day == '0
            && hour == '0 && minute == '0 && weekday == '0)
        else $error("fields not cleared on invalid result");
    a_ranges_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> month >= 4'd1 && month <= 4'd12 && day != 5'd0
            && hour <= 5'd23 && minute <= 6'd59 && weekday <= 3'd6)
        else $error("valid result with field out of range");
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid)
        else $error("popped request not presented");
`endif

endmodule
